// ===== rtl/epc_pkg.sv =====
// shared types, field widths, codes and defaults of the eye pixel compositor
package epc_pkg;

  // default image geometry
  localparam int SCREEN_SIDE_DEF   = 128;
  localparam int SCLERA_SIDE_DEF   = 256;
  localparam int IRIS_SIDE_DEF     = 80;
  localparam int IRIS_MAP_COLS_DEF = 512;
  localparam int IRIS_MAP_ROWS_DEF = 80;

  // item and register field widths
  localparam int ROW_W    = 8;
  localparam int COL_W    = 9;
  localparam int FUNC_W   = 3;
  localparam int VALUE_W  = 16;
  localparam int PIX_W    = 16;
  localparam int LID_W    = 8;
  localparam int SCALE_W  = 13;
  localparam int OFS_W    = 8;
  localparam int THR_W    = 8;
  localparam int PADDR_W  = 5;
  localparam int PDATA_W  = 32;

  // polar word: distance in the low bits, angle above it
  localparam int DIST_W      = 7;
  localparam int ANG_W       = 9;
  localparam int SCALE_SHIFT = 7;   // iris scale is in 1/128 units
  localparam int ANG_SHIFT   = 9;   // angle spans 512 steps

  // cycles from an accepted render to its result strobe
  localparam int PIPE_LAT = 8;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_SCLERA = 3'd0,
    FUNC_UPPER  = 3'd1,
    FUNC_LOWER  = 3'd2,
    FUNC_POLAR  = 3'd3,
    FUNC_IRIS   = 3'd4,
    FUNC_RENDER = 3'd5
  } func_t;

  typedef enum logic [2:0] {
    REG_IRIS_SCALE = 3'd0,
    REG_X_OFFSET   = 3'd1,
    REG_Y_OFFSET   = 3'd2,
    REG_UPPER_THR  = 3'd3,
    REG_LOWER_THR  = 3'd4
  } reg_idx_t;

  localparam logic [SCALE_W-1:0] IRIS_SCALE_RST = 13'd128;
  localparam logic [OFS_W-1:0]   X_OFFSET_RST   = 8'd36;
  localparam logic [OFS_W-1:0]   Y_OFFSET_RST   = 8'd36;
  localparam logic [THR_W-1:0]   UPPER_THR_RST  = 8'd0;
  localparam logic [THR_W-1:0]   LOWER_THR_RST  = 8'd0;

endpackage

// ===== rtl/epc_ram.sv =====
// single-port image store with registered read data
module epc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rdata_r <= mem_r[addr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/eye_pixel_compositor.sv =====
// eye pixel compositor top level: store loading and render pipeline
//
// Input items arrive on start with in_func, in_row, in_col and in_value and
// are accepted when start is high and busy is low; busy is low whenever the
// block is out of reset, so one item may enter in every clock cycle.
// Write items (sclera, upper lid, lower lid, polar, iris map) load one word
// into one store and give no result; out-of-range writes are dropped.
// A render item gives exactly one result: out_pixel_color with a one-cycle
// out_strobe. Throughput is one item per cycle, set by the five single-port
// stores, each of which sees at most one access per cycle. Writes reach a
// store at the same pipeline stage as render reads of it, so items take effect
// in arrival order.
// The pipeline is: coordinate sums, window and wrap, address multiply,
// lid/sclera/polar read, distance scaling, iris address multiply, iris read,
// color select. The receiver cannot stall; results are never held back.
// Registers sit on an APB-style port at byte address 4*index; the user must write them only
// while no item is in flight; the block does not enforce this. Synchronous reset empties the
// pipeline and loads register defaults; store contents stay undefined until written.
module eye_pixel_compositor #(
  parameter int SCREEN_SIDE   = epc_pkg::SCREEN_SIDE_DEF,
  parameter int SCLERA_SIDE   = epc_pkg::SCLERA_SIDE_DEF,
  parameter int IRIS_SIDE     = epc_pkg::IRIS_SIDE_DEF,
  parameter int IRIS_MAP_COLS = epc_pkg::IRIS_MAP_COLS_DEF,
  parameter int IRIS_MAP_ROWS = epc_pkg::IRIS_MAP_ROWS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [epc_pkg::FUNC_W-1:0]   in_func,
  input  logic [epc_pkg::ROW_W-1:0]    in_row,
  input  logic [epc_pkg::COL_W-1:0]    in_col,
  input  logic [epc_pkg::VALUE_W-1:0]  in_value,
  output logic                         out_strobe,
  output logic [epc_pkg::PIX_W-1:0]    out_pixel_color,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [epc_pkg::PADDR_W-1:0]  paddr,
  input  logic [epc_pkg::PDATA_W-1:0]  pwdata,
  output logic [epc_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready
);

  import epc_pkg::*;

  localparam int SCR_W     = $clog2(SCREEN_SIDE);
  localparam int LID_DEPTH = SCREEN_SIDE * SCREEN_SIDE;
  localparam int LID_AW    = $clog2(LID_DEPTH);
  localparam int SCL_W     = $clog2(SCLERA_SIDE);
  localparam int SCL_DEPTH = SCLERA_SIDE * SCLERA_SIDE;
  localparam int SCL_AW    = $clog2(SCL_DEPTH);
  localparam int IRS_W     = $clog2(IRIS_SIDE);
  localparam int POL_DEPTH = IRIS_SIDE * IRIS_SIDE;
  localparam int POL_AW    = $clog2(POL_DEPTH);
  localparam int IMR_W     = $clog2(IRIS_MAP_ROWS);
  localparam int IMC_W     = $clog2(IRIS_MAP_COLS);
  localparam int IRC_DEPTH = IRIS_MAP_ROWS * IRIS_MAP_COLS;
  localparam int IRC_AW    = $clog2(IRC_DEPTH);
  localparam int IRIS_OFS  = (SCLERA_SIDE - IRIS_SIDE) / 2;
  localparam int SUMX_W    = COL_W + 1;
  localparam int SUMY_W    = ROW_W + 1;
  localparam int PROD_W    = SCALE_W + DIST_W;
  localparam int DIST_FULL_W = PROD_W - SCALE_SHIFT;
  localparam int APROD_W   = ANG_W + IMC_W + 1;

  // configuration registers
  logic [SCALE_W-1:0] iris_scale_r;
  logic [OFS_W-1:0]   x_offset_r;
  logic [OFS_W-1:0]   y_offset_r;
  logic [THR_W-1:0]   upper_thr_r;
  logic [THR_W-1:0]   lower_thr_r;
  logic               cfg_wr;
  logic [2:0]         cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iris_scale_r <= IRIS_SCALE_RST;
      x_offset_r   <= X_OFFSET_RST;
      y_offset_r   <= Y_OFFSET_RST;
      upper_thr_r  <= UPPER_THR_RST;
      lower_thr_r  <= LOWER_THR_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_IRIS_SCALE: iris_scale_r <= pwdata[SCALE_W-1:0];
        REG_X_OFFSET:   x_offset_r   <= pwdata[OFS_W-1:0];
        REG_Y_OFFSET:   y_offset_r   <= pwdata[OFS_W-1:0];
        REG_UPPER_THR:  upper_thr_r  <= pwdata[THR_W-1:0];
        REG_LOWER_THR:  lower_thr_r  <= pwdata[THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_IRIS_SCALE: prdata = PDATA_W'(iris_scale_r);
      REG_X_OFFSET:   prdata = PDATA_W'(x_offset_r);
      REG_Y_OFFSET:   prdata = PDATA_W'(y_offset_r);
      REG_UPPER_THR:  prdata = PDATA_W'(upper_thr_r);
      REG_LOWER_THR:  prdata = PDATA_W'(lower_thr_r);
      default:        prdata = '0;
    endcase
  end

  // input transfer
  logic in_acc;
  assign busy   = ~rst_n;
  assign in_acc = start & ~busy;

  // ---------------- stage 1: latch item, form coordinate sums
  logic                 s1_valid_r;
  logic [FUNC_W-1:0]    s1_func_r;
  logic [ROW_W-1:0]     s1_row_r;
  logic [COL_W-1:0]     s1_col_r;
  logic [VALUE_W-1:0]   s1_value_r;
  logic [SUMX_W-1:0]    s1_sumx_r;
  logic [SUMY_W-1:0]    s1_sumy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    s1_func_r  <= in_func;
    s1_row_r   <= in_row;
    s1_col_r   <= in_col;
    s1_value_r <= in_value;
    s1_sumx_r  <= SUMX_W'(x_offset_r) + SUMX_W'(in_col);
    s1_sumy_r  <= SUMY_W'(y_offset_r) + SUMY_W'(in_row);
  end

  // ---------------- stage 2: bounds, wrap and iris window
  logic                 s1_on_scr, s1_in_scl, s1_in_pol, s1_in_map;
  logic                 s1_win_x, s1_win_y;
  logic [SUMX_W-1:0]    s1_ix;
  logic [SUMY_W-1:0]    s1_iy;
  logic [8:0]           s1_sx_mod, s1_sy_mod;
  logic                 s1_rnd;

  assign s1_rnd    = s1_valid_r && (s1_func_r == FUNC_RENDER);
  assign s1_on_scr = ({1'b0, s1_row_r} < 9'(SCREEN_SIDE)) && (s1_col_r < 9'(SCREEN_SIDE));
  assign s1_in_scl = ({1'b0, s1_row_r} < 9'(SCLERA_SIDE)) && (s1_col_r < 9'(SCLERA_SIDE));
  assign s1_in_pol = ({1'b0, s1_row_r} < 9'(IRIS_SIDE)) && (s1_col_r < 9'(IRIS_SIDE));
  assign s1_in_map = ({1'b0, s1_row_r} < 9'(IRIS_MAP_ROWS))
                     && ({1'b0, s1_col_r} < 10'(IRIS_MAP_COLS));

  // window position uses the unwrapped sums
  assign s1_ix    = s1_sumx_r - SUMX_W'(IRIS_OFS);
  assign s1_iy    = s1_sumy_r - SUMY_W'(IRIS_OFS);
  assign s1_win_x = (s1_sumx_r >= SUMX_W'(IRIS_OFS)) && (s1_ix < SUMX_W'(IRIS_SIDE));
  assign s1_win_y = (s1_sumy_r >= SUMY_W'(IRIS_OFS)) && (s1_iy < SUMY_W'(IRIS_SIDE));

  // sclera position wraps at 256, then at the sclera side
  assign s1_sx_mod = ({1'b0, s1_sumx_r[7:0]} >= 9'(SCLERA_SIDE))
                     ? {1'b0, s1_sumx_r[7:0]} - 9'(SCLERA_SIDE) : {1'b0, s1_sumx_r[7:0]};
  assign s1_sy_mod = ({1'b0, s1_sumy_r[7:0]} >= 9'(SCLERA_SIDE))
                     ? {1'b0, s1_sumy_r[7:0]} - 9'(SCLERA_SIDE) : {1'b0, s1_sumy_r[7:0]};

  logic                 s2_rnd_r, s2_up_we_r, s2_lo_we_r, s2_scl_we_r, s2_pol_we_r;
  logic                 s2_irc_we_r;
  logic                 s2_on_scr_r, s2_inside_r;
  logic [SCR_W-1:0]     s2_lid_row_r, s2_lid_col_r;
  logic [SCL_W-1:0]     s2_scl_row_r, s2_scl_col_r;
  logic [IRS_W-1:0]     s2_pol_row_r, s2_pol_col_r;
  logic [IMR_W-1:0]     s2_map_row_r;
  logic [IMC_W-1:0]     s2_map_col_r;
  logic [VALUE_W-1:0]   s2_value_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_rnd_r    <= 1'b0;
      s2_up_we_r  <= 1'b0;
      s2_lo_we_r  <= 1'b0;
      s2_scl_we_r <= 1'b0;
      s2_pol_we_r <= 1'b0;
      s2_irc_we_r <= 1'b0;
    end else begin
      s2_rnd_r    <= s1_rnd;
      s2_up_we_r  <= s1_valid_r && (s1_func_r == FUNC_UPPER) && s1_on_scr;
      s2_lo_we_r  <= s1_valid_r && (s1_func_r == FUNC_LOWER) && s1_on_scr;
      s2_scl_we_r <= s1_valid_r && (s1_func_r == FUNC_SCLERA) && s1_in_scl;
      s2_pol_we_r <= s1_valid_r && (s1_func_r == FUNC_POLAR) && s1_in_pol;
      s2_irc_we_r <= s1_valid_r && (s1_func_r == FUNC_IRIS) && s1_in_map;
    end
  end

  always_ff @(posedge clk) begin
    s2_on_scr_r  <= s1_on_scr;
    s2_inside_r  <= s1_win_x && s1_win_y;
    s2_lid_row_r <= s1_row_r[SCR_W-1:0];
    s2_lid_col_r <= s1_col_r[SCR_W-1:0];
    s2_scl_row_r <= s1_rnd ? s1_sy_mod[SCL_W-1:0] : s1_row_r[SCL_W-1:0];
    s2_scl_col_r <= s1_rnd ? s1_sx_mod[SCL_W-1:0] : s1_col_r[SCL_W-1:0];
    s2_pol_row_r <= s1_rnd ? s1_iy[IRS_W-1:0] : s1_row_r[IRS_W-1:0];
    s2_pol_col_r <= s1_rnd ? s1_ix[IRS_W-1:0] : s1_col_r[IRS_W-1:0];
    s2_map_row_r <= s1_row_r[IMR_W-1:0];
    s2_map_col_r <= s1_col_r[IMC_W-1:0];
    s2_value_r   <= s1_value_r;
  end

  // ---------------- stage 3: store addresses
  logic                 s3_rnd_r, s3_up_we_r, s3_lo_we_r, s3_scl_we_r, s3_pol_we_r;
  logic                 s3_irc_we_r;
  logic                 s3_on_scr_r, s3_inside_r;
  logic [LID_AW-1:0]    s3_lid_addr_r;
  logic [SCL_AW-1:0]    s3_scl_addr_r;
  logic [POL_AW-1:0]    s3_pol_addr_r;
  logic [IMR_W-1:0]     s3_map_row_r;
  logic [IMC_W-1:0]     s3_map_col_r;
  logic [VALUE_W-1:0]   s3_value_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_rnd_r    <= 1'b0;
      s3_up_we_r  <= 1'b0;
      s3_lo_we_r  <= 1'b0;
      s3_scl_we_r <= 1'b0;
      s3_pol_we_r <= 1'b0;
      s3_irc_we_r <= 1'b0;
    end else begin
      s3_rnd_r    <= s2_rnd_r;
      s3_up_we_r  <= s2_up_we_r;
      s3_lo_we_r  <= s2_lo_we_r;
      s3_scl_we_r <= s2_scl_we_r;
      s3_pol_we_r <= s2_pol_we_r;
      s3_irc_we_r <= s2_irc_we_r;
    end
  end

  always_ff @(posedge clk) begin
    s3_on_scr_r   <= s2_on_scr_r;
    s3_inside_r   <= s2_inside_r;
    s3_lid_addr_r <= LID_AW'(s2_lid_row_r) * LID_AW'(SCREEN_SIDE) + LID_AW'(s2_lid_col_r);
    s3_scl_addr_r <= SCL_AW'(s2_scl_row_r) * SCL_AW'(SCLERA_SIDE) + SCL_AW'(s2_scl_col_r);
    s3_pol_addr_r <= POL_AW'(s2_pol_row_r) * POL_AW'(IRIS_SIDE) + POL_AW'(s2_pol_col_r);
    s3_map_row_r  <= s2_map_row_r;
    s3_map_col_r  <= s2_map_col_r;
    s3_value_r    <= s2_value_r;
  end

  // first store bank: lids, sclera and polar map
  logic [LID_W-1:0]   up_rdata, lo_rdata;
  logic [PIX_W-1:0]   scl_rdata;
  logic [VALUE_W-1:0] pol_rdata;

  epc_ram #(.WIDTH(LID_W), .DEPTH(LID_DEPTH)) u_upper_lid (
    .clk(clk), .we(s3_up_we_r), .addr(s3_lid_addr_r),
    .wdata(s3_value_r[LID_W-1:0]), .rdata(up_rdata)
  );

  epc_ram #(.WIDTH(LID_W), .DEPTH(LID_DEPTH)) u_lower_lid (
    .clk(clk), .we(s3_lo_we_r), .addr(s3_lid_addr_r),
    .wdata(s3_value_r[LID_W-1:0]), .rdata(lo_rdata)
  );

  epc_ram #(.WIDTH(PIX_W), .DEPTH(SCL_DEPTH)) u_sclera (
    .clk(clk), .we(s3_scl_we_r), .addr(s3_scl_addr_r),
    .wdata(s3_value_r), .rdata(scl_rdata)
  );

  epc_ram #(.WIDTH(VALUE_W), .DEPTH(POL_DEPTH)) u_polar (
    .clk(clk), .we(s3_pol_we_r), .addr(s3_pol_addr_r),
    .wdata(s3_value_r), .rdata(pol_rdata)
  );

  // ---------------- stage 4: control beside the first read data
  logic                 s4_rnd_r, s4_irc_we_r, s4_on_scr_r, s4_inside_r;
  logic [IMR_W-1:0]     s4_map_row_r;
  logic [IMC_W-1:0]     s4_map_col_r;
  logic [VALUE_W-1:0]   s4_value_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_rnd_r    <= 1'b0;
      s4_irc_we_r <= 1'b0;
    end else begin
      s4_rnd_r    <= s3_rnd_r;
      s4_irc_we_r <= s3_irc_we_r;
    end
  end

  always_ff @(posedge clk) begin
    s4_on_scr_r  <= s3_on_scr_r;
    s4_inside_r  <= s3_inside_r;
    s4_map_row_r <= s3_map_row_r;
    s4_map_col_r <= s3_map_col_r;
    s4_value_r   <= s3_value_r;
  end

  // ---------------- stage 5: lid test, distance scaling, angle to column
  logic [APROD_W-1:0]   s4_ang_prod;
  assign s4_ang_prod = APROD_W'(IRIS_MAP_COLS) * APROD_W'(pol_rdata[VALUE_W-1 -: ANG_W]);

  logic                 s5_rnd_r, s5_irc_we_r, s5_on_scr_r, s5_inside_r, s5_covered_r;
  logic [PROD_W-1:0]    s5_prod_r;
  logic [IMC_W-1:0]     s5_ang_col_r;
  logic [PIX_W-1:0]     s5_scl_color_r;
  logic [IMR_W-1:0]     s5_map_row_r;
  logic [IMC_W-1:0]     s5_map_col_r;
  logic [VALUE_W-1:0]   s5_value_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_rnd_r    <= 1'b0;
      s5_irc_we_r <= 1'b0;
    end else begin
      s5_rnd_r    <= s4_rnd_r;
      s5_irc_we_r <= s4_irc_we_r;
    end
  end

  always_ff @(posedge clk) begin
    s5_on_scr_r    <= s4_on_scr_r;
    s5_inside_r    <= s4_inside_r;
    s5_covered_r   <= (lo_rdata <= lower_thr_r) || (up_rdata <= upper_thr_r);
    s5_prod_r      <= PROD_W'(iris_scale_r) * PROD_W'(pol_rdata[DIST_W-1:0]);
    s5_ang_col_r   <= s4_ang_prod[ANG_SHIFT +: IMC_W];
    s5_scl_color_r <= scl_rdata;
    s5_map_row_r   <= s4_map_row_r;
    s5_map_col_r   <= s4_map_col_r;
    s5_value_r     <= s4_value_r;
  end

  // ---------------- stage 6: iris map address
  logic [DIST_FULL_W-1:0] s5_dist;
  logic                   s5_dist_ok;
  logic [IMR_W-1:0]       s5_irc_row;
  logic [IMC_W-1:0]       s5_irc_col;

  assign s5_dist    = s5_prod_r[PROD_W-1:SCALE_SHIFT];
  assign s5_dist_ok = s5_dist < DIST_FULL_W'(IRIS_MAP_ROWS);
  assign s5_irc_row = s5_irc_we_r ? s5_map_row_r : s5_dist[IMR_W-1:0];
  assign s5_irc_col = s5_irc_we_r ? s5_map_col_r : s5_ang_col_r;

  logic                 s6_rnd_r, s6_irc_we_r, s6_zero_r, s6_use_iris_r;
  logic [IRC_AW-1:0]    s6_irc_addr_r;
  logic [PIX_W-1:0]     s6_scl_color_r;
  logic [VALUE_W-1:0]   s6_value_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s6_rnd_r    <= 1'b0;
      s6_irc_we_r <= 1'b0;
    end else begin
      s6_rnd_r    <= s5_rnd_r;
      s6_irc_we_r <= s5_irc_we_r;
    end
  end

  always_ff @(posedge clk) begin
    s6_zero_r      <= !s5_on_scr_r || s5_covered_r;
    s6_use_iris_r  <= s5_inside_r && s5_dist_ok;
    s6_irc_addr_r  <= IRC_AW'(s5_irc_row) * IRC_AW'(IRIS_MAP_COLS) + IRC_AW'(s5_irc_col);
    s6_scl_color_r <= s5_scl_color_r;
    s6_value_r     <= s5_value_r;
  end

  logic [PIX_W-1:0] irc_rdata;

  epc_ram #(.WIDTH(PIX_W), .DEPTH(IRC_DEPTH)) u_iris_map (
    .clk(clk), .we(s6_irc_we_r), .addr(s6_irc_addr_r),
    .wdata(s6_value_r), .rdata(irc_rdata)
  );

  // ---------------- stage 7: beside the iris read data
  logic                 s7_rnd_r, s7_zero_r, s7_use_iris_r;
  logic [PIX_W-1:0]     s7_scl_color_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s7_rnd_r <= 1'b0;
    end else begin
      s7_rnd_r <= s6_rnd_r;
    end
  end

  always_ff @(posedge clk) begin
    s7_zero_r      <= s6_zero_r;
    s7_use_iris_r  <= s6_use_iris_r;
    s7_scl_color_r <= s6_scl_color_r;
  end

  // ---------------- output register: color select
  logic             out_strobe_r;
  logic [PIX_W-1:0] out_color_r, out_color_nxt;

  always_comb begin
    if (s7_zero_r) begin
      out_color_nxt = '0;
    end else if (s7_use_iris_r) begin
      out_color_nxt = irc_rdata;
    end else begin
      out_color_nxt = s7_scl_color_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= s7_rnd_r;
    end
  end

  always_ff @(posedge clk) begin
    out_color_r <= out_color_nxt;
  end

  assign out_strobe      = out_strobe_r;
  assign out_pixel_color = out_color_r;

endmodule

// ===== rtl/epc_checker.sv =====
// port-level checks of the eye pixel compositor, bound to the top level
module epc_checker #(
  parameter int SCREEN_SIDE = epc_pkg::SCREEN_SIDE_DEF
) (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        start,
  input logic                        busy,
  input logic [epc_pkg::FUNC_W-1:0]  in_func,
  input logic [epc_pkg::ROW_W-1:0]   in_row,
  input logic [epc_pkg::COL_W-1:0]   in_col,
  input logic                        out_strobe,
  input logic [epc_pkg::PIX_W-1:0]   out_pixel_color
);

  import epc_pkg::*;

  logic rnd_acc, off_screen;
  assign rnd_acc    = start && !busy && (in_func == FUNC_RENDER);
  assign off_screen = ({1'b0, in_row} >= 9'(SCREEN_SIDE)) || (in_col >= 9'(SCREEN_SIDE));

  // every result traces back to a render transfer
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(rnd_acc, PIPE_LAT))
    else $error("result without a render transfer");

  // every render transfer gives its result after the pipeline latency
  a_no_loss: assert property (@(posedge clk) disable iff (!rst_n)
    rnd_acc |-> ##PIPE_LAT out_strobe)
    else $error("render transfer lost");

  // an off-screen render yields black
  a_off_screen: assert property (@(posedge clk) disable iff (!rst_n)
    (rnd_acc && off_screen) |-> ##PIPE_LAT (out_pixel_color == '0))
    else $error("off-screen pixel not black");

  // reset empties the pipeline
  a_reset_flush: assert property (@(posedge clk)
    !rst_n |=> !out_strobe)
    else $error("result right after reset");

endmodule

bind eye_pixel_compositor epc_checker #(.SCREEN_SIDE(SCREEN_SIDE)) u_epc_checker (
  .clk(clk),
  .rst_n(rst_n),
  .start(start),
  .busy(busy),
  .in_func(in_func),
  .in_row(in_row),
  .in_col(in_col),
  .out_strobe(out_strobe),
  .out_pixel_color(out_pixel_color)
);

// ===== tb/testbench.sv =====
// self-checking testbench for the eye pixel compositor: store loads, renders and registers
module testbench;
  import epc_pkg::*;

  localparam int SCREEN      = SCREEN_SIDE_DEF;
  localparam int SCLERA      = SCLERA_SIDE_DEF;
  localparam int IRIS        = IRIS_SIDE_DEF;
  localparam int MAP_COLS    = IRIS_MAP_COLS_DEF;
  localparam int MAP_ROWS    = IRIS_MAP_ROWS_DEF;
  localparam int IRIS_ORIGIN = (SCLERA - IRIS) / 2;
  localparam int CYCLE_LIMIT = 200000;

  // codes the block must ignore
  localparam logic [FUNC_W-1:0] FUNC_SPARE_LO = 3'd6;
  localparam logic [FUNC_W-1:0] FUNC_SPARE_HI = 3'd7;
  localparam logic [2:0]        REG_SPARE_LO  = 3'd5;
  localparam logic [2:0]        REG_SPARE_HI  = 3'd7;

  logic                 clk      = 1'b0;
  logic                 rst_n    = 1'b0;
  logic                 start    = 1'b0;
  logic                 busy;
  logic [FUNC_W-1:0]    in_func  = '0;
  logic [ROW_W-1:0]     in_row   = '0;
  logic [COL_W-1:0]     in_col   = '0;
  logic [VALUE_W-1:0]   in_value = '0;
  logic                 out_strobe;
  logic [PIX_W-1:0]     out_pixel_color;
  logic                 psel     = 1'b0;
  logic                 penable  = 1'b0;
  logic                 pwrite   = 1'b0;
  logic [PADDR_W-1:0]   paddr    = '0;
  logic [PDATA_W-1:0]   pwdata   = '0;
  logic [PDATA_W-1:0]   prdata;
  logic                 pready;

  eye_pixel_compositor dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_func        (in_func),
    .in_row         (in_row),
    .in_col         (in_col),
    .in_value       (in_value),
    .out_strobe     (out_strobe),
    .out_pixel_color(out_pixel_color),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always #4 clk = ~clk;

  // image model of the block
  logic [PIX_W-1:0] sclera_mem [SCLERA*SCLERA];
  logic [LID_W-1:0] upper_mem  [SCREEN*SCREEN];
  logic [LID_W-1:0] lower_mem  [SCREEN*SCREEN];
  logic [PIX_W-1:0] polar_mem  [IRIS*IRIS];
  logic [PIX_W-1:0] iris_mem   [MAP_ROWS*MAP_COLS];
  bit               sclera_set [SCLERA*SCLERA];
  bit               upper_set  [SCREEN*SCREEN];
  bit               lower_set  [SCREEN*SCREEN];
  bit               polar_set  [IRIS*IRIS];
  bit               iris_set   [MAP_ROWS*MAP_COLS];

  logic [SCALE_W-1:0] cfg_scale     = IRIS_SCALE_RST;
  logic [OFS_W-1:0]   cfg_xoff      = X_OFFSET_RST;
  logic [OFS_W-1:0]   cfg_yoff      = Y_OFFSET_RST;
  logic [THR_W-1:0]   cfg_upper_thr = UPPER_THR_RST;
  logic [THR_W-1:0]   cfg_lower_thr = LOWER_THR_RST;

  logic [PIX_W-1:0] pending_pixels [$];
  logic [PIX_W-1:0] want_pixel;
  int               mismatch_count = 0;
  int               burst_left     = 0;
  int               cycle_count    = 0;

  function automatic void note_mismatch(string what, logic [31:0] want, logic [31:0] got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("mismatch %0d: %s expected %h got %h", mismatch_count, what, want, got);
  endfunction

  // store addresses a render touches; -1 where the pixel does not reach that store
  function automatic void locate(input int x, input int y, output int sc_idx,
                                 output int pol_idx, output int iris_idx);
    int ix, iy, dist_row, ang;
    logic [PIX_W-1:0] pw;
    sc_idx   = (((int'(cfg_yoff) + y) & 255) % SCLERA) * SCLERA
             + (((int'(cfg_xoff) + x) & 255) % SCLERA);
    pol_idx  = -1;
    iris_idx = -1;
    ix = int'(cfg_xoff) + x - IRIS_ORIGIN;
    iy = int'(cfg_yoff) + y - IRIS_ORIGIN;
    if (ix < 0 || iy < 0 || ix >= IRIS || iy >= IRIS) return;
    pol_idx = iy * IRIS + ix;
    pw   = polar_mem[pol_idx];
    dist_row = (int'(cfg_scale) * int'(pw[DIST_W-1:0])) / 128;
    if (dist_row >= MAP_ROWS) return;
    ang = (MAP_COLS * int'(pw[PIX_W-1:DIST_W])) / 512;
    if (ang >= MAP_COLS) ang = MAP_COLS - 1;
    iris_idx = dist_row * MAP_COLS + ang;
  endfunction

  function automatic logic [PIX_W-1:0] predict_pixel(int x, int y);
    int lid_idx, sc, pol, ir;
    if (x >= SCREEN || y >= SCREEN) return '0;
    lid_idx = y * SCREEN + x;
    if (lower_mem[lid_idx] <= cfg_lower_thr || upper_mem[lid_idx] <= cfg_upper_thr)
      return '0;
    locate(x, y, sc, pol, ir);
    if (ir < 0) return sclera_mem[sc];
    return iris_mem[ir];
  endfunction

  function automatic void apply_to_image_model(logic [FUNC_W-1:0] func, int row, int col,
                                               logic [VALUE_W-1:0] value);
    case (func)
      FUNC_SCLERA: if (row < SCLERA && col < SCLERA) begin
        sclera_mem[row*SCLERA+col] = value;
        sclera_set[row*SCLERA+col] = 1'b1;
      end
      FUNC_UPPER: if (row < SCREEN && col < SCREEN) begin
        upper_mem[row*SCREEN+col] = value[LID_W-1:0];
        upper_set[row*SCREEN+col] = 1'b1;
      end
      FUNC_LOWER: if (row < SCREEN && col < SCREEN) begin
        lower_mem[row*SCREEN+col] = value[LID_W-1:0];
        lower_set[row*SCREEN+col] = 1'b1;
      end
      FUNC_POLAR: if (row < IRIS && col < IRIS) begin
        polar_mem[row*IRIS+col] = value;
        polar_set[row*IRIS+col] = 1'b1;
      end
      FUNC_IRIS: if (row < MAP_ROWS && col < MAP_COLS) begin
        iris_mem[row*MAP_COLS+col] = value;
        iris_set[row*MAP_COLS+col] = 1'b1;
      end
      FUNC_RENDER: pending_pixels.push_back(predict_pixel(col, row));
      default: ;
    endcase
  endfunction

  function automatic bit entry_written(logic [FUNC_W-1:0] func, int row, int col);
    case (func)
      FUNC_SCLERA: return sclera_set[row*SCLERA+col];
      FUNC_UPPER:  return upper_set[row*SCREEN+col];
      FUNC_LOWER:  return lower_set[row*SCREEN+col];
      FUNC_POLAR:  return polar_set[row*IRIS+col];
      FUNC_IRIS:   return iris_set[row*MAP_COLS+col];
      default:     return 1'b1;
    endcase
  endfunction

  function automatic logic [PADDR_W-1:0] reg_addr(logic [2:0] idx);
    return {idx, 2'b00};
  endfunction

  // one item transfer, with sender bursts and gaps
  task automatic send_item(input logic [FUNC_W-1:0] func, input int row, input int col,
                           input logic [VALUE_W-1:0] value);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 5);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 6);
    end
    burst_left--;
    start    <= 1'b1;
    in_func  <= func;
    in_row   <= ROW_W'(row);
    in_col   <= COL_W'(col);
    in_value <= value;
    @(posedge clk);
    while (busy) @(posedge clk);
    apply_to_image_model(func, row, col, value);
  endtask

  task automatic fill_entry(logic [FUNC_W-1:0] func, int row, int col);
    if (!entry_written(func, row, col)) send_item(func, row, col, VALUE_W'($urandom));
  endtask

  // load every entry the pixel will read, then render it
  task automatic render_at(int x, int y);
    int sc, pol, ir;
    fill_entry(FUNC_UPPER, y, x);
    fill_entry(FUNC_LOWER, y, x);
    locate(x, y, sc, pol, ir);
    fill_entry(FUNC_SCLERA, sc / SCLERA, sc % SCLERA);
    if (pol >= 0) fill_entry(FUNC_POLAR, pol / IRIS, pol % IRIS);
    locate(x, y, sc, pol, ir);
    if (ir >= 0) fill_entry(FUNC_IRIS, ir / MAP_COLS, ir % MAP_COLS);
    send_item(FUNC_RENDER, y, x, VALUE_W'($urandom));
  endtask

  task automatic drain_pipeline();
    start <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    // writes give no result and may still be in flight
    repeat (PIPE_LAT + 2) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= reg_addr(idx);
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      REG_IRIS_SCALE: cfg_scale     = data[SCALE_W-1:0];
      REG_X_OFFSET:   cfg_xoff      = data[OFS_W-1:0];
      REG_Y_OFFSET:   cfg_yoff      = data[OFS_W-1:0];
      REG_UPPER_THR:  cfg_upper_thr = data[THR_W-1:0];
      REG_LOWER_THR:  cfg_lower_thr = data[THR_W-1:0];
      default: ;
    endcase
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_reg(logic [2:0] idx, logic [31:0] want);
    logic [31:0] got;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= reg_addr(idx);
    @(posedge clk);
    penable <= 1'b1;
    // read data is sampled mid access phase
    @(negedge clk);
    got = prdata;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (got !== want) note_mismatch("register readback", want, got);
    @(posedge clk);
  endtask

  task automatic check_all_regs();
    check_reg(REG_IRIS_SCALE, 32'(cfg_scale));
    check_reg(REG_X_OFFSET, 32'(cfg_xoff));
    check_reg(REG_Y_OFFSET, 32'(cfg_yoff));
    check_reg(REG_UPPER_THR, 32'(cfg_upper_thr));
    check_reg(REG_LOWER_THR, 32'(cfg_lower_thr));
  endtask

  task automatic random_items(int count);
    int done, kind, x, y;
    done = 0;
    while (done < count) begin
      kind = $urandom_range(0, 99);
      if (kind < 5) begin
        send_item($urandom_range(0, 1) ? FUNC_SPARE_HI : FUNC_SPARE_LO, $urandom_range(0, 255),
                  $urandom_range(0, 511), VALUE_W'($urandom));
      end else begin
        done++;
        if (kind < 25) begin
          send_item(FUNC_W'($urandom_range(0, 4)), $urandom_range(0, 255),
                    $urandom_range(0, 511), VALUE_W'($urandom));
        end else if (kind < 33) begin
          if ($urandom_range(0, 1)) begin
            x = $urandom_range(SCREEN, 511);
            y = $urandom_range(0, 255);
          end else begin
            x = $urandom_range(0, 511);
            y = $urandom_range(SCREEN, 255);
          end
          send_item(FUNC_RENDER, y, x, VALUE_W'($urandom));
        end else if (kind < 65) begin
          // aim at the iris window
          x = IRIS_ORIGIN + int'($urandom_range(0, IRIS - 1)) - int'(cfg_xoff);
          y = IRIS_ORIGIN + int'($urandom_range(0, IRIS - 1)) - int'(cfg_yoff);
          if (x < 0 || x >= SCREEN) x = $urandom_range(0, SCREEN - 1);
          if (y < 0 || y >= SCREEN) y = $urandom_range(0, SCREEN - 1);
          render_at(x, y);
        end else begin
          render_at($urandom_range(0, SCREEN - 1), $urandom_range(0, SCREEN - 1));
        end
      end
    end
  endtask

  task automatic test_register_defaults();
    check_all_regs();
  endtask

  task automatic test_directed_items();
    send_item(FUNC_SCLERA, 36, 36, 16'hFFFF);
    send_item(FUNC_UPPER, 0, 0, 16'h00FF);
    send_item(FUNC_LOWER, 0, 0, 16'h0001);
    // out of range writes must not land anywhere
    send_item(FUNC_SCLERA, 36, 292, 16'h1234);
    send_item(FUNC_UPPER, 128, 0, 16'h0000);
    send_item(FUNC_LOWER, 0, 128, 16'h0000);
    send_item(FUNC_RENDER, 0, 0, 16'h0000);
    send_item(FUNC_SPARE_LO, 0, 0, 16'hFFFF);
    send_item(FUNC_SPARE_HI, 255, 511, 16'h0000);
    send_item(FUNC_RENDER, 255, 511, 16'hFFFF);
    send_item(FUNC_RENDER, 0, SCREEN, 16'h0000);
    send_item(FUNC_RENDER, SCREEN, 0, 16'h0000);
    // lid value at the threshold covers the pixel
    send_item(FUNC_UPPER, 0, 0, 16'h0000);
    send_item(FUNC_RENDER, 0, 0, 16'h0000);
    send_item(FUNC_UPPER, 100, 100, 16'h0080);
    send_item(FUNC_LOWER, 100, 100, 16'h0080);
    send_item(FUNC_SCLERA, 136, 136, 16'h5555);
    send_item(FUNC_POLAR, 48, 48, 16'hFF85);
    send_item(FUNC_IRIS, 5, 511, 16'hABCD);
    send_item(FUNC_IRIS, 85, 511, 16'h0000);
    send_item(FUNC_POLAR, 200, 48, 16'h0000);
    send_item(FUNC_RENDER, 100, 100, 16'h0000);
    // distance past the map rows falls back to sclera
    send_item(FUNC_POLAR, 48, 48, 16'h007F);
    send_item(FUNC_RENDER, 100, 100, 16'h0000);
    render_at(SCREEN - 1, SCREEN - 1);
    render_at(0, SCREEN - 1);
  endtask

  task automatic test_unknown_register();
    drain_pipeline();
    write_reg(REG_SPARE_LO, $urandom);
    write_reg(REG_SPARE_HI, $urandom);
    check_all_regs();
  endtask

  task automatic test_render_setting(logic [31:0] scale, logic [31:0] xoff, logic [31:0] yoff,
                                     logic [31:0] upper_thr, logic [31:0] lower_thr, int count);
    drain_pipeline();
    write_reg(REG_IRIS_SCALE, scale);
    write_reg(REG_X_OFFSET, xoff);
    write_reg(REG_Y_OFFSET, yoff);
    write_reg(REG_UPPER_THR, upper_thr);
    write_reg(REG_LOWER_THR, lower_thr);
    check_all_regs();
    random_items(count);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      if (pending_pixels.size() == 0) begin
        note_mismatch("pixel with no render pending", '0, 32'(out_pixel_color));
      end else begin
        want_pixel = pending_pixels.pop_front();
        if (out_pixel_color !== want_pixel) note_mismatch("pixel_color", 32'(want_pixel),
                                                          32'(out_pixel_color));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[eye_pixel_compositor] ERROR");
      $finish;
    end
  end

  // renders load the entries they read, so a counted render step may send several items
  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_register_defaults();
    test_directed_items();
    test_unknown_register();
    test_render_setting(32'd8191, 32'd0, 32'd0, 32'd0, 32'd0, 24);
    test_render_setting(32'd0, 32'd88, 32'd88, 32'd128, 32'd0, 24);
    test_render_setting(32'd300, 32'd255, 32'd255, 32'd0, 32'd255, 24);
    test_render_setting(32'd64, 32'd200, 32'd20, 32'd255, 32'd255, 16);
    test_render_setting($urandom, $urandom, $urandom, $urandom, $urandom, 24);
    test_render_setting(32'd128, 32'd36, 32'd36, 32'd0, 32'd0, 24);
    drain_pipeline();
    if (mismatch_count == 0 && pending_pixels.size() == 0) begin
      $display("[eye_pixel_compositor] OK");
    end else begin
      $display("[eye_pixel_compositor] ERROR");
    end
    $finish;
  end

endmodule

// ===== eye_pixel_compositor.f =====
rtl/epc_pkg.sv
rtl/epc_ram.sv
rtl/eye_pixel_compositor.sv
rtl/epc_checker.sv
tb/testbench.sv
